// ===== rtl/kpd_pkg.sv =====
`timescale 1ns / 1ps

package kpd_pkg;

    // Number of keys served by the per-slot store.
    localparam int KEY_SLOTS = 8;

    // Width of a store address; at least one bit so a single-key build still works.
    localparam int SLOT_IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    // Fixed field widths of the stream payloads.
    localparam int SLOT_W   = 3;
    localparam int TICK_W   = 32;
    localparam int THRESH_W = 16;
    localparam int CFG_IW   = 2;

    // Packed tdata widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [2:0] {
        CLS_IDLE,
        CLS_PRESSED,
        CLS_LONG,
        CLS_LONG_LONG,
        CLS_LONGEST,
        CLS_RELEASED
    } key_class_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_DOWN,
        EV_UP
    } key_event_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        REG_PRESS_TIME,
        REG_LONG_TIME,
        REG_LONG_LONG_TIME,
        REG_LONGEST_TIME
    } cfg_reg_t;

    // One entry of the per-slot store.
    typedef struct packed {
        logic [TICK_W-1:0] start_time;
        logic              timing;
        logic              is_pressed;
        logic              is_released;
        logic              was_sent;
        key_class_t        class_code;
    } kpd_entry_t;

    // The four hold thresholds.
    typedef struct packed {
        logic [THRESH_W-1:0] press_time;
        logic [THRESH_W-1:0] long_time;
        logic [THRESH_W-1:0] long_long_time;
        logic [THRESH_W-1:0] longest_time;
    } kpd_thresh_t;

    // Store write request from the update stage.
    typedef struct packed {
        logic               en;
        logic [SLOT_IW-1:0] idx;
        kpd_entry_t         data;
    } kpd_wr_t;

    // Maps a slot field onto a store address.
    function automatic logic [SLOT_IW-1:0] slot_index(input logic [SLOT_W-1:0] slot);
        logic [SLOT_IW+SLOT_W-1:0] wide;
        wide = {{SLOT_IW{1'b0}}, slot};
        return wide[SLOT_IW-1:0];
    endfunction

    // True when the slot field names a key that the store holds.
    function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
        return 32'(slot) < 32'(KEY_SLOTS);
    endfunction

endpackage

// ===== rtl/kpd_store.sv =====
`timescale 1ns / 1ps

module kpd_store
    import kpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [SLOT_IW-1:0] rd_idx,
    input  kpd_wr_t            wr,
    output kpd_entry_t         rd_entry
);

    kpd_entry_t mem [KEY_SLOTS];

    logic [KEY_SLOTS-1:0] vld_reg;
    kpd_entry_t           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 fwd_reg;
    kpd_entry_t           fwd_data_reg;

    // Entry storage, written by the update stage.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wr.data;
        end
    end

    // Written flags: an entry not yet written reads as the reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_idx];
                // A write to the same entry in the read cycle wins over the stale array data.
                fwd_reg    <= wr.en && (wr.idx == rd_idx);
            end
        end
    end

    always_comb begin
        if (fwd_reg) begin
            rd_entry = fwd_data_reg;
        end else if (rd_vld_reg) begin
            rd_entry = rd_data_reg;
        end else begin
            rd_entry = '0;
        end
    end

endmodule

// ===== rtl/kpd_update.sv =====
`timescale 1ns / 1ps

module kpd_update
    import kpd_pkg::*;
(
    input  kpd_entry_t        cur,
    input  logic              pin_high,
    input  logic [TICK_W-1:0] now_ticks,
    input  kpd_thresh_t       thresh,
    output kpd_entry_t        nxt,
    output key_event_t        event_res
);

    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] dur;
    logic              over_press;
    logic              over_long;
    logic              over_long_long;
    logic              over_longest;

    // Hold time since the press began, modulo 2^32.
    assign start          = cur.timing ? cur.start_time : now_ticks;
    assign dur            = now_ticks - start;
    assign over_press     = dur > TICK_W'(thresh.press_time);
    assign over_long      = dur > TICK_W'(thresh.long_time);
    assign over_long_long = dur > TICK_W'(thresh.long_long_time);
    assign over_longest   = dur > TICK_W'(thresh.longest_time);

    // Class stepping and event selection; later checks override earlier ones.
    always_comb begin
        nxt       = cur;
        event_res = EV_NONE;
        if (!pin_high) begin
            nxt.timing     = 1'b1;
            nxt.start_time = start;
            if (over_press && !cur.is_pressed) begin
                nxt.is_pressed  = 1'b1;
                nxt.is_released = 1'b0;
                nxt.was_sent    = 1'b0;
                nxt.class_code  = CLS_PRESSED;
            end
            if (nxt.is_pressed) begin
                if (over_long) begin
                    nxt.is_released = 1'b0;
                    nxt.was_sent    = 1'b0;
                    nxt.class_code  = CLS_LONG;
                end
                if (over_long_long) begin
                    nxt.is_released = 1'b0;
                    nxt.was_sent    = 1'b0;
                    nxt.class_code  = CLS_LONG_LONG;
                end
                if (over_longest) begin
                    nxt.is_released = 1'b0;
                    nxt.was_sent    = 1'b0;
                    nxt.class_code  = CLS_LONGEST;
                end
            end
        end else begin
            if (cur.is_pressed) begin
                nxt.is_released = 1'b1;
                nxt.was_sent    = 1'b0;
                nxt.class_code  = CLS_RELEASED;
            end
            nxt.is_pressed = 1'b0;
            nxt.timing     = 1'b0;
        end

        if (!nxt.was_sent) begin
            if (nxt.is_pressed) begin
                event_res    = EV_DOWN;
                nxt.was_sent = 1'b1;
            end else if (nxt.is_released) begin
                event_res    = EV_UP;
                nxt.was_sent = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/key_press_duration_classifier.sv =====
`timescale 1ns / 1ps

// Key press duration classifier.
// Each beat on the s_ channel is one poll of one active-low key: the slot,
// the sampled pin level and a free-running tick count. Each poll gives
// exactly one beat on the m_ channel with the slot, an event (none, key
// down, key up) and the key's hold class.
// One poll is accepted every cycle while s_tready is high; its slot's entry
// is read from the per-slot store in the accept cycle, updated and written
// back as it moves into the output register, and a write that meets a read
// of the same slot is forwarded into the read result. Thresholds must be
// written over the cfg port while the block is idle; the block does not enforce it.
// Reset clears the thresholds to their defaults, empties the pipeline and
// marks every slot entry unwritten, so each reads as idle; no clearing pass
// is needed and a poll may be accepted in the first cycle after reset.
// When the receiver stalls, the result stays in the output register and one
// more poll may sit in the update stage; after that s_tready drops.
module key_press_duration_classifier
    import kpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IW-1:0]     cfg_addr,
    input  logic [THRESH_W-1:0]   cfg_wr_data,
    // Poll input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // slot[2:0], pin_high[3], now_ticks[35:4], zero
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // slot_out[2:0], event_res[4:3], key_class[7:5]
);

    kpd_thresh_t thresh_reg;

    logic              st1_v_reg;
    logic [SLOT_W-1:0] st1_slot_reg;
    logic              st1_in_range_reg;
    logic              st1_pin_reg;
    logic [TICK_W-1:0] st1_now_reg;

    logic              out_v_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    key_event_t        out_ev_reg;
    key_class_t        out_cls_reg;

    logic              out_free;
    logic              st1_adv;
    logic              s_fire;
    logic [SLOT_W-1:0] s_slot;
    kpd_entry_t        cur_entry;
    kpd_entry_t        nxt_entry;
    key_event_t        upd_event;
    kpd_wr_t           wr;

    // Handshake between the stages.
    assign s_slot   = s_tdata[SLOT_W-1:0];
    assign out_free = !out_v_reg || m_tready;
    assign st1_adv  = st1_v_reg && out_free;
    assign s_tready = !st1_v_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.press_time     <= THRESH_W'(50);
            thresh_reg.long_time      <= THRESH_W'(1000);
            thresh_reg.long_long_time <= THRESH_W'(3000);
            thresh_reg.longest_time   <= THRESH_W'(5000);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PRESS_TIME:     thresh_reg.press_time     <= cfg_wr_data;
                REG_LONG_TIME:      thresh_reg.long_time      <= cfg_wr_data;
                REG_LONG_LONG_TIME: thresh_reg.long_long_time <= cfg_wr_data;
                REG_LONGEST_TIME:   thresh_reg.longest_time   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Per-slot store.
    kpd_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .rd_idx   (slot_index(s_slot)),
        .wr       (wr),
        .rd_entry (cur_entry)
    );

    // Update stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
        end else if (s_tready) begin
            st1_v_reg <= s_tvalid;
        end
    end

    // Update stage payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_slot_reg     <= s_slot;
            st1_in_range_reg <= slot_in_range(s_slot);
            st1_pin_reg      <= s_tdata[SLOT_W];
            st1_now_reg      <= s_tdata[SLOT_W+TICK_W:SLOT_W+1];
        end
    end

    kpd_update u_update (
        .cur       (cur_entry),
        .pin_high  (st1_pin_reg),
        .now_ticks (st1_now_reg),
        .thresh    (thresh_reg),
        .nxt       (nxt_entry),
        .event_res (upd_event)
    );

    // Write-back happens as the result moves into the output register.
    assign wr.en   = st1_adv && st1_in_range_reg;
    assign wr.idx  = slot_index(st1_slot_reg);
    assign wr.data = nxt_entry;

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg <= st1_v_reg;
        end
    end

    // Output register payload; a slot outside the store reports idle.
    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_slot_reg <= st1_slot_reg;
            if (st1_in_range_reg) begin
                out_ev_reg  <= upd_event;
                out_cls_reg <= nxt_entry.class_code;
            end else begin
                out_ev_reg  <= EV_NONE;
                out_cls_reg <= CLS_IDLE;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_cls_reg, out_ev_reg, out_slot_reg};

endmodule

// ===== rtl/kpd_checker.sv =====
`timescale 1ns / 1ps

module kpd_checker
    import kpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A key-down event only comes with a held class.
    a_down_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:3] == EV_DOWN |->
            m_tdata[7:5] == CLS_PRESSED || m_tdata[7:5] == CLS_LONG ||
            m_tdata[7:5] == CLS_LONG_LONG || m_tdata[7:5] == CLS_LONGEST)
        else $error("key-down with a class that is not held");

    // A key-up event only comes with the released class.
    a_up_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:3] == EV_UP |-> m_tdata[7:5] == CLS_RELEASED)
        else $error("key-up without the released class");

    // A poll accepted while the output is idle and drained reaches m_tvalid after the update stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
        else $error("accepted poll did not produce a result");

endmodule

bind key_press_duration_classifier kpd_checker u_kpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_key_press_duration_classifier.sv =====
`timescale 1ns / 1ps

module tb_key_press_duration_classifier;
    import kpd_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 9;
    localparam int IDLE_LIMIT      = 4000;
    localparam int RX_HOLD_CYCLES  = 100;

    // One poll result as the block reports it.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        key_event_t        ev;
        key_class_t        cls;
    } poll_result_t;

    // One row of the directed stimulus; the expected result is typed in only
    // where it can be read off directly.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              pin_high;
        logic [TICK_W-1:0] now_ticks;
        bit                typed;
        key_event_t        ev;
        key_class_t        cls;
    } poll_row_t;

    // Threshold sets used by the random phases.
    typedef enum {
        LIMITS_ZERO,
        LIMITS_FULL,
        LIMITS_RAMP,
        LIMITS_SCRAMBLED,
        LIMITS_DEFAULT
    } limit_set_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IW-1:0]    cfg_addr    = '0;
    logic [THRESH_W-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the thresholds and of the per-key store.
    logic [THRESH_W-1:0] hold_limit [4];
    logic [TICK_W-1:0]   hold_start [KEY_SLOTS];
    logic                hold_timed [KEY_SLOTS];
    logic                key_down   [KEY_SLOTS];
    logic                key_up     [KEY_SLOTS];
    logic                ev_sent    [KEY_SLOTS];
    key_class_t          key_cls    [KEY_SLOTS];

    poll_result_t results_due [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int rx_hold_req   = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;
    logic [31:0] rx_cycle = '0;

    key_press_duration_classifier uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Directed polls at the default thresholds 50, 1000, 3000 and 5000.
    poll_row_t directed_rows [23] = '{
        // Released poll straight after reset.
        '{3'd0, 1'b1, 32'd0,          1'b1, EV_NONE, CLS_IDLE},
        // Hold starts; at exactly the press threshold nothing happens yet.
        '{3'd0, 1'b0, 32'd100,        1'b1, EV_NONE, CLS_IDLE},
        '{3'd0, 1'b0, 32'd150,        1'b1, EV_NONE, CLS_IDLE},
        '{3'd0, 1'b0, 32'd151,        1'b1, EV_DOWN, CLS_PRESSED},
        '{3'd0, 1'b0, 32'd152,        1'b1, EV_NONE, CLS_PRESSED},
        // Past the long threshold key-down repeats on every poll.
        '{3'd0, 1'b0, 32'd1101,       1'b1, EV_DOWN, CLS_LONG},
        '{3'd0, 1'b0, 32'd1102,       1'b1, EV_DOWN, CLS_LONG},
        '{3'd0, 1'b1, 32'd1200,       1'b1, EV_UP,   CLS_RELEASED},
        '{3'd0, 1'b1, 32'd1300,       1'b1, EV_NONE, CLS_RELEASED},
        '{3'd0, 1'b0, 32'd2000,       1'b0, EV_NONE, CLS_IDLE},
        // Hold time across the timestamp wrap.
        '{3'd1, 1'b0, 32'hFFFF_FFF0,  1'b1, EV_NONE, CLS_IDLE},
        '{3'd1, 1'b0, 32'h0000_0100,  1'b0, EV_NONE, CLS_IDLE},
        // Release of a press that was never recognized.
        '{3'd2, 1'b0, 32'd5,          1'b0, EV_NONE, CLS_IDLE},
        '{3'd2, 1'b1, 32'd10,         1'b0, EV_NONE, CLS_IDLE},
        // One poll jumps straight to the longest class; on slot 4 one jumps to long-long.
        '{3'd3, 1'b0, 32'd0,          1'b0, EV_NONE, CLS_IDLE},
        '{3'd3, 1'b0, 32'd5001,       1'b0, EV_NONE, CLS_IDLE},
        '{3'd4, 1'b0, 32'd7,          1'b0, EV_NONE, CLS_IDLE},
        '{3'd4, 1'b0, 32'd3008,       1'b0, EV_NONE, CLS_IDLE},
        // Highest slot and highest timestamp.
        '{3'd7, 1'b0, 32'hFFFF_FFFF,  1'b1, EV_NONE, CLS_IDLE},
        '{3'd7, 1'b0, 32'hFFFF_FFFF,  1'b0, EV_NONE, CLS_IDLE},
        '{3'd7, 1'b1, 32'd0,          1'b0, EV_NONE, CLS_IDLE},
        '{3'd5, 1'b0, 32'hAAAA_AAAA,  1'b0, EV_NONE, CLS_IDLE},
        '{3'd6, 1'b0, 32'h5555_5555,  1'b0, EV_NONE, CLS_IDLE}
    };

    // Reports one mismatch on one line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch at result %0d: got %0d, expected %0d",
                 $time, what, results_seen, got, want);
    endtask

    // Raises the class once the hold passes a later threshold.
    task automatic promote_hold(input int k, input logic [TICK_W-1:0] held_for,
                                input logic [THRESH_W-1:0] limit, input key_class_t cls);
        if (held_for > 32'(limit) && key_down[k]) begin
            key_up[k]  = 1'b0;
            ev_sent[k] = 1'b0;
            key_cls[k] = cls;
        end
    endtask

    // Classifies one poll against the shadow store and updates it.
    task automatic classify_poll(input logic [SLOT_W-1:0] slot, input logic pin_high,
                                 input logic [TICK_W-1:0] now_ticks,
                                 output poll_result_t res);
        logic [TICK_W-1:0] held_for;
        int k;
        k = int'(slot);
        res.slot = slot;
        res.ev   = EV_NONE;
        res.cls  = CLS_IDLE;
        if (k < KEY_SLOTS) begin
            if (!pin_high) begin
                if (!hold_timed[k]) begin
                    hold_timed[k] = 1'b1;
                    hold_start[k] = now_ticks;
                end
                held_for = now_ticks - hold_start[k];
                if (held_for > 32'(hold_limit[REG_PRESS_TIME]) && !key_down[k]) begin
                    key_down[k] = 1'b1;
                    key_up[k]   = 1'b0;
                    ev_sent[k]  = 1'b0;
                    key_cls[k]  = CLS_PRESSED;
                end
                promote_hold(k, held_for, hold_limit[REG_LONG_TIME], CLS_LONG);
                promote_hold(k, held_for, hold_limit[REG_LONG_LONG_TIME], CLS_LONG_LONG);
                promote_hold(k, held_for, hold_limit[REG_LONGEST_TIME], CLS_LONGEST);
            end else begin
                if (key_down[k]) begin
                    key_up[k]  = 1'b1;
                    ev_sent[k] = 1'b0;
                    key_cls[k] = CLS_RELEASED;
                end
                key_down[k]   = 1'b0;
                hold_timed[k] = 1'b0;
            end
            if (!ev_sent[k]) begin
                if (key_down[k]) begin
                    res.ev     = EV_DOWN;
                    ev_sent[k] = 1'b1;
                end else if (key_up[k]) begin
                    res.ev     = EV_UP;
                    ev_sent[k] = 1'b1;
                end
            end
            res.cls = key_cls[k];
        end
    endtask

    // Offers one poll in bursts with random gaps and queues its expected result.
    task automatic send_poll(input logic [SLOT_W-1:0] slot, input logic pin_high,
                             input logic [TICK_W-1:0] now_ticks, input bit typed,
                             input poll_result_t typed_res);
        poll_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, now_ticks, pin_high, slot};
        do @(posedge aclk); while (!s_tready);
        classify_poll(slot, pin_high, now_ticks, predicted);
        results_due.push_back(typed ? typed_res : predicted);
    endtask

    // Stops offering polls and waits for every expected result.
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    // Writes all four thresholds back to back; called at a rising edge.
    task automatic write_thresholds(input limit_set_t kind);
        logic [THRESH_W-1:0] v [4];
        case (kind)
            LIMITS_ZERO: begin
                foreach (v[i]) v[i] = '0;
            end
            LIMITS_FULL: begin
                foreach (v[i]) v[i] = '1;
            end
            LIMITS_RAMP: begin
                v[REG_PRESS_TIME]     = THRESH_W'($urandom_range(0, 300));
                v[REG_LONG_TIME]      = THRESH_W'(v[REG_PRESS_TIME]
                                                  + $urandom_range(1, 3000));
                v[REG_LONG_LONG_TIME] = THRESH_W'(v[REG_LONG_TIME]
                                                  + $urandom_range(1, 3000));
                v[REG_LONGEST_TIME]   = THRESH_W'(v[REG_LONG_LONG_TIME]
                                                  + $urandom_range(1, 3000));
            end
            LIMITS_SCRAMBLED: begin
                foreach (v[i]) v[i] = THRESH_W'($urandom_range(0, 65535));
            end
            default: begin
                v[REG_PRESS_TIME]     = 16'd50;
                v[REG_LONG_TIME]      = 16'd1000;
                v[REG_LONG_LONG_TIME] = 16'd3000;
                v[REG_LONGEST_TIME]   = 16'd5000;
            end
        endcase
        for (int r = 0; r < 4; r++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= cfg_reg_t'(r);
            cfg_wr_data <= v[r];
            @(posedge aclk);
            hold_limit[r] = v[r];
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Hold time for a held poll: mostly right around one of the thresholds.
    function automatic logic [TICK_W-1:0] pick_hold_time();
        logic [TICK_W-1:0] base;
        case ($urandom_range(0, 5))
            0: base = 32'(hold_limit[REG_PRESS_TIME]);
            1: base = 32'(hold_limit[REG_LONG_TIME]);
            2: base = 32'(hold_limit[REG_LONG_LONG_TIME]);
            3: base = 32'(hold_limit[REG_LONGEST_TIME]);
            4: return $urandom_range(0, 70000);
            default: return $urandom;
        endcase
        return base + $urandom_range(0, 2) - 1;
    endfunction

    // Main sequence: reset, directed rows, then random phases with new thresholds.
    initial begin
        poll_result_t typed_res;
        logic [SLOT_W-1:0] slot;
        logic pin_high;
        logic [TICK_W-1:0] now_ticks;

        hold_limit[REG_PRESS_TIME]     = 16'd50;
        hold_limit[REG_LONG_TIME]      = 16'd1000;
        hold_limit[REG_LONG_LONG_TIME] = 16'd3000;
        hold_limit[REG_LONGEST_TIME]   = 16'd5000;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            hold_start[k] = '0;
            hold_timed[k] = 1'b0;
            key_down[k]   = 1'b0;
            key_up[k]     = 1'b0;
            ev_sent[k]    = 1'b0;
            key_cls[k]    = CLS_IDLE;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            typed_res.slot = directed_rows[i].slot;
            typed_res.ev   = directed_rows[i].ev;
            typed_res.cls  = directed_rows[i].cls;
            send_poll(directed_rows[i].slot, directed_rows[i].pin_high,
                      directed_rows[i].now_ticks, directed_rows[i].typed, typed_res);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_thresholds(limit_set_t'(phase % 5));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver hold-off while polls keep coming.
                if ((phase == 1 || phase == 6) && n == 50)
                    rx_hold_req <= rx_hold_req + 1;
                slot     = SLOT_W'($urandom_range(0, KEY_SLOTS - 1));
                pin_high = ($urandom_range(0, 3) == 0);
                if (hold_timed[slot] && $urandom_range(0, 9) != 0)
                    now_ticks = hold_start[slot] + pick_hold_time();
                else
                    now_ticks = $urandom;
                send_poll(slot, pin_high, now_ticks, 1'b0, typed_res);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_key_press_duration_classifier OK");
        else
            $display("tb_key_press_duration_classifier NOT OK");
        $finish;
    end

    // Receiver: switches between stall patterns and honors long hold-off requests.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Result checker: each beat against the oldest expectation, field by field.
    always @(posedge aclk) begin
        poll_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result beat", int'(m_tdata), -1);
            end else begin
                want = results_due.pop_front();
                if (m_tdata[2:0] !== want.slot)
                    report_mismatch("slot_out", int'(m_tdata[2:0]), int'(want.slot));
                if (m_tdata[4:3] !== want.ev)
                    report_mismatch("event_res", int'(m_tdata[4:3]), int'(want.ev));
                if (m_tdata[7:5] !== want.cls)
                    report_mismatch("key_class", int'(m_tdata[7:5]), int'(want.cls));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_key_press_duration_classifier NOT OK");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/kpd_pkg.sv
rtl/kpd_store.sv
rtl/kpd_update.sv
rtl/key_press_duration_classifier.sv
rtl/kpd_checker.sv
verif/tb_key_press_duration_classifier.sv
